>>> sv/skt_pkg.sv
// Package for the sorted key table: sizes, request and status codes, and
// controller states. No dependencies; every other file of the block but skt_ram imports it.
`default_nettype none
package skt_pkg;

  // Table size and derived widths.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and response beats.
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned TOTAL_W  = 7;
  localparam int unsigned CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_MISSING   = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

>>> sv/skt_if.sv
// Request and response channel interfaces of the sorted key table.
// Depends on skt_pkg for the field widths.
`default_nettype none
interface skt_req_if import skt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [KEY_W-1:0]   key;
  logic [IDX_W-1:0]   index;

  modport source (output valid, req_type, key, index, input ready);
  modport sink   (input valid, req_type, key, index, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [POS_W-1:0]   position;
  logic [KEY_W-1:0]   key_out;
  logic [TOTAL_W-1:0] entry_total;

  modport source (output valid, status, position, key_out, entry_total, input ready);
  modport sink   (input valid, status, position, key_out, entry_total, output ready);
endinterface
`default_nettype wire

>>> sv/skt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module skt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> sv/sorted_key_table.sv
// Sorted key table top level: controller plus the key memory.
// Depends on skt_pkg, skt_req_if, skt_rsp_if and skt_ram.
//
// Usage:
//   Requests arrive as beats on req_i (insert, remove, lookup, read at index)
//   and each one produces exactly one response beat on rsp_o, in order.
//   Keys are held ascending in a single synchronous RAM. A request is taken
//   only while the controller is idle; it then walks the RAM one entry per
//   cycle, reading one entry and writing back a shifted one in the same cycle.
//   Insert walks down from the top entry, moving larger keys up one slot.
//   Remove and lookup walk up from entry 0; a remove moves the later keys
//   down one slot. A read at an index reads a single entry; failing requests
//   without a scan go straight to the result. The walk is paced by the
//   single read port of the key memory.
//   The response sits in an output register: the next request is accepted
//   while it waits, and a finished result waits in the controller until the
//   output register frees up, so a stalled receiver stalls the table.
//   Reset clears the entry count and empties both channels; the memory is
//   not cleared, since entries at or above the count are never read.
`default_nettype none
module sorted_key_table import skt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  skt_req_if.sink   req_i,
  skt_rsp_if.source rsp_o
);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  req_type_e           op_q, op_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [ADDR_W-1:0]   ptr_q, ptr_d;
  logic [ADDR_W-1:0]   pos_q, pos_d;
  logic                found_q, found_d;
  status_e             res_status_q, res_status_d;
  logic [POS_W-1:0]    res_pos_q, res_pos_d;
  logic [KEY_W-1:0]    res_key_q, res_key_d;

  logic                out_valid_q, out_valid_d;
  logic [1:0]          out_status_q, out_status_d;
  logic [POS_W-1:0]    out_pos_q, out_pos_d;
  logic [KEY_W-1:0]    out_key_q, out_key_d;
  logic [TOTAL_W-1:0]  out_total_q, out_total_d;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [KEY_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [KEY_W-1:0]    ram_rdata;

  logic                req_fire;
  logic [CNT_W-1:0]    cnt_m1;
  logic [ADDR_W-1:0]   last_addr;
  logic                at_last;
  logic                out_free;
  req_type_e           req_op;

  skt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and helper terms.
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_op      = req_type_e'(req_i.req_type);
  assign cnt_m1      = cnt_q - CNT_W'(1);
  assign last_addr   = cnt_m1[ADDR_W-1:0];
  assign at_last     = (ptr_q == last_addr);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.position    = out_pos_q;
  assign rsp_o.key_out     = out_key_q;
  assign rsp_o.entry_total = out_total_q;

  // Controller: next state, memory accesses and result.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    op_d         = op_q;
    key_d        = key_q;
    ptr_d        = ptr_q;
    pos_d        = pos_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_key_d    = res_key_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_key_d    = out_key_q;
    out_total_d  = out_total_q;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = ptr_q;

    // The response register drains whenever the receiver takes the beat.
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          op_d         = req_op;
          key_d        = req_i.key;
          found_d      = 1'b0;
          res_status_d = ST_OK;
          res_pos_d    = '0;
          res_key_d    = '0;
          case (req_op)
            REQ_INSERT: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                res_status_d = ST_FULL;
                state_d      = S_DONE;
              end else if (cnt_q == '0) begin
                pos_d   = '0;
                state_d = S_WRITE;
              end else begin
                ptr_d     = last_addr;
                ram_re    = 1'b1;
                ram_raddr = last_addr;
                state_d   = S_SCAN;
              end
            end
            REQ_REMOVE, REQ_LOOKUP: begin
              if (cnt_q == '0) begin
                res_status_d = ST_MISSING;
                state_d      = S_DONE;
              end else begin
                ptr_d     = '0;
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = S_SCAN;
              end
            end
            default: begin
              if (CMP_W'(req_i.index) < CMP_W'(cnt_q)) begin
                ptr_d     = ADDR_W'(req_i.index);
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(req_i.index);
                res_pos_d = req_i.index;
                state_d   = S_SCAN;
              end else begin
                res_status_d = ST_BAD_INDEX;
                state_d      = S_DONE;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        case (op_q)
          REQ_INSERT: begin
            // Walk down; keys greater than the new one move up a slot.
            if (ram_rdata > key_q) begin
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(ptr_q + 1'b1);
              if (ptr_q == '0) begin
                pos_d   = '0;
                state_d = S_WRITE;
              end else begin
                ptr_d     = ADDR_W'(ptr_q - 1'b1);
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(ptr_q - 1'b1);
              end
            end else begin
              pos_d   = ADDR_W'(ptr_q + 1'b1);
              state_d = S_WRITE;
            end
          end
          REQ_REMOVE, REQ_LOOKUP: begin
            if (found_q) begin
              // Closing the gap: each later key moves down one slot.
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(ptr_q - 1'b1);
              if (at_last) begin
                cnt_d   = cnt_m1;
                state_d = S_DONE;
              end else begin
                ptr_d     = ADDR_W'(ptr_q + 1'b1);
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(ptr_q + 1'b1);
              end
            end else if (ram_rdata == key_q) begin
              res_pos_d = POS_W'(ptr_q);
              if (op_q == REQ_LOOKUP) begin
                state_d = S_DONE;
              end else if (at_last) begin
                cnt_d   = cnt_m1;
                state_d = S_DONE;
              end else begin
                found_d   = 1'b1;
                ptr_d     = ADDR_W'(ptr_q + 1'b1);
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(ptr_q + 1'b1);
              end
            end else if (at_last) begin
              res_status_d = ST_MISSING;
              state_d      = S_DONE;
            end else begin
              ptr_d     = ADDR_W'(ptr_q + 1'b1);
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(ptr_q + 1'b1);
            end
          end
          default: begin
            res_key_d = ram_rdata;
            state_d   = S_DONE;
          end
        endcase
      end

      S_WRITE: begin
        // Drop the new key into the slot freed by the scan.
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = key_q;
        res_pos_d = POS_W'(pos_q);
        cnt_d     = CNT_W'(cnt_q + 1'b1);
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = res_pos_q;
          out_key_d    = res_key_q;
          out_total_d  = TOTAL_W'(cnt_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    ptr_q        <= ptr_d;
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_key_q    <= res_key_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_key_q    <= out_key_d;
    out_total_q  <= out_total_d;
  end

endmodule
`default_nettype wire

>>> tb/sorted_key_table_tb.sv
// Self-checking testbench for the sorted key table: directed table, then random traffic.
// Depends on skt_pkg, skt_req_if, skt_rsp_if and the sorted_key_table RTL.
// Every response beat is compared against a fixed answer (typed rows) or a behavioral copy.
module sorted_key_table_tb;
  import skt_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 6;
  localparam int N_RANDOM        = 1100;
  localparam int PHASE_ITEMS     = 90;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int DRAIN_CYCLES    = 2 * CAPACITY + 20;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int N_DIRECTED      = 23;

  localparam logic [KEY_W-1:0] KEY_ZERO   = '0;
  localparam logic [KEY_W-1:0] KEY_MAX    = '1;
  localparam logic [KEY_W-1:0] KEY_ALT    = {32{2'b01}};
  localparam logic [KEY_W-1:0] KEY_TOPBIT = {1'b1, 62'h0, 1'b1};
  localparam logic [KEY_W-1:0] ID_ALICE   = {"ALICE", 24'h0};
  localparam logic [KEY_W-1:0] ID_ALICE0  = {"ALICE0", 16'h0};
  localparam logic [KEY_W-1:0] ID_BOB     = {"BOB", 40'h0};
  localparam logic [KEY_W-1:0] ID_A       = {"A", 56'h0};

  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [KEY_W-1:0]   key_out;
    logic [TOTAL_W-1:0] entry_total;
  } resp_t;

  typedef struct packed {
    req_type_e        kind;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] index;
    bit               typed;
    resp_t            answer;
  } dir_row_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } load_mix_e;

  localparam resp_t UNTYPED = '0;

  logic clk = 1'b0;
  logic rst_n;

  skt_req_if req_bus ();
  skt_rsp_if rsp_bus ();

  sorted_key_table uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Behavioral copy of the table contents.
  logic [KEY_W-1:0] held_keys [CAPACITY];
  int unsigned      held_count = 0;

  resp_t expected_q [$];
  int    error_count    = 0;
  bit    sender_gaps_on = 1'b1;
  bit    hold_off_req   = 1'b0;

  // Directed rows. Typed answers are the obvious ones; the rest use the table copy.
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{REQ_READ,   KEY_ZERO, 6'd0,  1'b1, '{ST_BAD_INDEX, 6'd0, KEY_ZERO, 7'd0}},
    '{REQ_LOOKUP, ID_ALICE, 6'd0,  1'b1, '{ST_MISSING,   6'd0, KEY_ZERO, 7'd0}},
    '{REQ_REMOVE, ID_ALICE, 6'd0,  1'b1, '{ST_MISSING,   6'd0, KEY_ZERO, 7'd0}},
    '{REQ_INSERT, KEY_MAX,  6'd0,  1'b1, '{ST_OK,        6'd0, KEY_ZERO, 7'd1}},
    '{REQ_INSERT, KEY_ZERO, 6'd63, 1'b1, '{ST_OK,        6'd0, KEY_ZERO, 7'd2}},
    '{REQ_READ,   KEY_MAX,  6'd0,  1'b1, '{ST_OK,        6'd0, KEY_ZERO, 7'd2}},
    '{REQ_READ,   KEY_ZERO, 6'd1,  1'b1, '{ST_OK,        6'd1, KEY_MAX,  7'd2}},
    '{REQ_READ,   KEY_ZERO, 6'd2,  1'b1, '{ST_BAD_INDEX, 6'd0, KEY_ZERO, 7'd2}},
    '{REQ_READ,   KEY_MAX,  6'd63, 1'b1, '{ST_BAD_INDEX, 6'd0, KEY_ZERO, 7'd2}},
    '{REQ_INSERT, KEY_MAX,  6'd0,  1'b1, '{ST_OK,        6'd2, KEY_ZERO, 7'd3}},
    '{REQ_LOOKUP, KEY_MAX,  6'd0,  1'b1, '{ST_OK,        6'd1, KEY_ZERO, 7'd3}},
    '{REQ_INSERT, ID_BOB,     6'd0,  1'b0, UNTYPED},
    '{REQ_INSERT, ID_ALICE,   6'd0,  1'b0, UNTYPED},
    '{REQ_INSERT, ID_ALICE,   6'd0,  1'b0, UNTYPED},
    '{REQ_INSERT, ID_ALICE0,  6'd0,  1'b0, UNTYPED},
    '{REQ_INSERT, ID_A,       6'd0,  1'b0, UNTYPED},
    '{REQ_LOOKUP, ID_ALICE,   6'd0,  1'b0, UNTYPED},
    '{REQ_REMOVE, ID_ALICE,   6'd0,  1'b0, UNTYPED},
    '{REQ_READ,   KEY_ALT,    6'd2,  1'b0, UNTYPED},
    '{REQ_LOOKUP, KEY_ALT,    6'd0,  1'b0, UNTYPED},
    '{REQ_REMOVE, KEY_ZERO,   6'd0,  1'b0, UNTYPED},
    '{REQ_REMOVE, KEY_MAX,    6'd0,  1'b0, UNTYPED},
    '{REQ_INSERT, KEY_TOPBIT, 6'd0,  1'b0, UNTYPED}
  };

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one request to the table copy and returns the response it should produce.
  function automatic resp_t apply_request(input req_type_e kind, input logic [KEY_W-1:0] k,
                                          input logic [IDX_W-1:0] idx);
    resp_t       r;
    int unsigned p;
    int unsigned i;
    r = UNTYPED;
    case (kind)
      REQ_INSERT: begin
        if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // New key goes after every key that is less than or equal to it.
          p = 0;
          while (p < held_count && held_keys[p] <= k) p++;
          for (i = held_count; i > p; i--) held_keys[i] = held_keys[i-1];
          held_keys[p] = k;
          held_count++;
          r.position = POS_W'(p);
        end
      end
      REQ_REMOVE, REQ_LOOKUP: begin
        // Scanning downward leaves the first match in p.
        p = held_count;
        for (i = held_count; i > 0; i--) begin
          if (held_keys[i-1] == k) p = i - 1;
        end
        if (p >= held_count) begin
          r.status = ST_MISSING;
        end else begin
          r.position = POS_W'(p);
          if (kind == REQ_REMOVE) begin
            for (i = p; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
            held_count--;
          end
        end
      end
      default: begin
        if (idx < held_count) begin
          r.position = idx;
          r.key_out  = held_keys[idx];
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end
    endcase
    r.entry_total = TOTAL_W'(held_count);
    return r;
  endfunction

  // Draws a key: raw random, a packed ID, a crowded small set, an extreme, or a held key.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               n;
    int               i;
    int               c;
    k = '0;
    case ($urandom_range(0, 9))
      0, 1: k = {$urandom, $urandom};
      2, 3: begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          c = $urandom_range(0, 35);
          k[KEY_W-1-8*i -: 8] = (c < 26) ? 8'(65 + c) : 8'(48 + c - 26);
        end
      end
      4, 5, 6: k = {8'(65 + $urandom_range(0, 2)), 8'(65 + $urandom_range(0, 2)), 48'h0};
      7: k = $urandom_range(0, 1) ? KEY_MAX : KEY_ZERO;
      default: begin
        if (held_count != 0) k = held_keys[$urandom_range(0, held_count - 1)];
        else k = {$urandom, $urandom};
      end
    endcase
    return k;
  endfunction

  function automatic void check_field(input string what, input logic [KEY_W-1:0] want,
                                      input logic [KEY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      error_count++;
    end
  endfunction

  // Offers one request beat after a random gap and records its response once accepted.
  task automatic issue(input req_type_e kind, input logic [KEY_W-1:0] k,
                       input logic [IDX_W-1:0] idx, input bit typed, input resp_t answer);
    int    gap;
    int    roll;
    resp_t predicted;
    roll = $urandom_range(0, 99);
    if (!sender_gaps_on || roll < 50) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(30, 80);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.key      <= k;
    req_bus.index    <= idx;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = apply_request(kind, k, idx);
    expected_q.push_back(typed ? answer : predicted);
  endtask

  // One random request, weighted by the current load mix.
  task automatic issue_random(input load_mix_e mix);
    int               roll;
    int               ins_w;
    int               rem_w;
    int               look_w;
    req_type_e        kind;
    logic [KEY_W-1:0] k;
    logic [IDX_W-1:0] idx;
    case (mix)
      MIX_FILL:  begin ins_w = 80; rem_w = 85; look_w = 93; end
      MIX_DRAIN: begin ins_w = 5;  rem_w = 85; look_w = 93; end
      default:   begin ins_w = 30; rem_w = 55; look_w = 80; end
    endcase
    roll = $urandom_range(0, 99);
    kind = (roll < ins_w) ? REQ_INSERT : (roll < rem_w) ? REQ_REMOVE :
           (roll < look_w) ? REQ_LOOKUP : REQ_READ;
    k   = pick_key();
    idx = IDX_W'($urandom_range(0, 63));
    // Most removes and lookups aim at a held key, most reads at a held position.
    if ((kind == REQ_REMOVE || kind == REQ_LOOKUP) && held_count != 0 &&
        $urandom_range(0, 9) < 7) begin
      k = held_keys[$urandom_range(0, held_count - 1)];
    end
    if (kind == REQ_READ && held_count != 0 && $urandom_range(0, 9) < 8) begin
      idx = IDX_W'($urandom_range(0, held_count - 1));
    end
    issue(kind, k, idx, 1'b0, UNTYPED);
  endtask

  // Main sequence: reset, directed table, random phases, then drain and verdict.
  initial begin
    int        row;
    int        sent;
    int        phase;
    int        i;
    load_mix_e mix;
    rst_n            <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_INSERT;
    req_bus.key      <= '0;
    req_bus.index    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < N_DIRECTED; row++) begin
      issue(directed_rows[row].kind, directed_rows[row].key, directed_rows[row].index,
            directed_rows[row].typed, directed_rows[row].answer);
    end

    // Phases cycle through fill-heavy, mixed, drain-heavy and mixed traffic.
    sent  = 0;
    phase = 0;
    while (sent < N_RANDOM) begin
      case (phase % 4)
        0:       mix = MIX_FILL;
        2:       mix = MIX_DRAIN;
        default: mix = MIX_BALANCED;
      endcase
      if (phase == 1) hold_off_req = 1'b1;
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < PHASE_ITEMS && sent < N_RANDOM; i++) begin
        issue_random(mix);
        sent++;
      end
      phase++;
    end
    req_bus.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("sorted_key_table_tb: PASS");
    end else begin
      $display("sorted_key_table_tb: FAIL");
    end
    $finish;
  end

  // Response side: random ready runs and stalls, plus one long hold-off on request.
  initial begin
    rsp_bus.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      rsp_bus.ready <= 1'b1;
      case ($urandom_range(0, 9))
        0:          repeat ($urandom_range(50, 150)) @(posedge clk);
        1, 2, 3:    repeat ($urandom_range(5, 20)) @(posedge clk);
        default:    repeat ($urandom_range(1, 4)) @(posedge clk);
      endcase
      rsp_bus.ready <= 1'b0;
      if (hold_off_req) begin
        // Long stall so that the table fills its output stage and blocks requests.
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0:             repeat ($urandom_range(20, 60)) @(posedge clk);
          1, 2, 3, 4, 5: repeat ($urandom_range(3, 8)) @(posedge clk);
          default:       repeat ($urandom_range(1, 2)) @(posedge clk);
        endcase
      end
    end
  end

  // Compare each accepted response beat against the oldest expectation.
  always @(posedge clk) begin : check_rsp
    resp_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual %0d %0d %h %0d", $time,
                 rsp_bus.status, rsp_bus.position, rsp_bus.key_out, rsp_bus.entry_total);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", KEY_W'(want.status), KEY_W'(rsp_bus.status));
        check_field("position", KEY_W'(want.position), KEY_W'(rsp_bus.position));
        check_field("key_out", want.key_out, rsp_bus.key_out);
        check_field("entry_total", KEY_W'(want.entry_total), KEY_W'(rsp_bus.entry_total));
      end
    end
  end

  // Watchdog: a run that hangs or loses responses ends here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sorted_key_table_tb: FAIL");
    $finish;
  end

endmodule
